[hw/rtl/arpc_pkg.sv]
// Shared types, codes and defaults of the ARP cache table.
`timescale 1ns / 1ps

package arpc_pkg;

   localparam int ENTRIES_DEF     = 16;
   localparam int HANDLE_BITS_DEF = 16;

   // slot numbers travel in a field wide enough for tables of up to 256 slots
   localparam int SLOT_IDX_W = 8;
   localparam int IP_W       = 32;
   localparam int MAC_W      = 48;
   localparam int PKT_W      = 16;
   localparam int TIME_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [TIME_W-1:0] ALIVE_TIMEOUT_RST = 32'd120000;
   localparam logic [TIME_W-1:0] DEAD_TIMEOUT_RST  = 32'd100000;
   localparam logic [TIME_W-1:0] WAIT_TIMEOUT_RST  = 32'd1000;

   typedef enum logic [2:0] {
      CMD_LOOKUP      = 3'd0,
      CMD_ADD         = 3'd1,
      CMD_MARK_WAIT   = 3'd2,
      CMD_UPDATE_WAIT = 3'd3,
      CMD_MARK_ALIVE  = 3'd4,
      CMD_MARK_DEAD   = 3'd5,
      CMD_FLUSH       = 3'd6,
      CMD_NOP         = 3'd7
   } arpc_cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_NOT_FOUND   = 2'd1,
      STATUS_WRONG_STATE = 2'd2,
      STATUS_TABLE_FULL  = 2'd3
   } arpc_status_type;

   typedef enum logic [1:0] {
      ST_ALIVE = 2'd0,
      ST_DEAD  = 2'd1,
      ST_WAIT  = 2'd2
   } arpc_slot_state_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ALIVE_TIMEOUT = 2'd0,
      CSR_DEAD_TIMEOUT  = 2'd1,
      CSR_WAIT_TIMEOUT  = 2'd2
   } arpc_csr_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SEARCH,
      FSM_REPORT
   } arpc_fsm_type;

   typedef struct packed {
      arpc_cmd_type      cmd;
      logic [IP_W-1:0]   ip_addr;
      logic [MAC_W-1:0]  mac_addr;
      logic [PKT_W-1:0]  packet_handle;
      logic [TIME_W-1:0] now;
   } arpc_req_type;

   typedef struct packed {
      arpc_status_type     status;
      logic                found;
      arpc_slot_state_type entry_state;
      logic [MAC_W-1:0]    mac_out;
      logic [PKT_W-1:0]    packet_out;
      logic                packet_valid;
      logic                expired;
   } arpc_rsp_type;

   // search token handed from cell to cell
   typedef struct packed {
      logic                  valid;
      logic                  hit;
      logic                  free;
      logic [SLOT_IDX_W-1:0] hit_idx;
      logic [SLOT_IDX_W-1:0] free_idx;
      arpc_slot_state_type   state;
      logic [MAC_W-1:0]      mac;
      logic [TIME_W-1:0]     last_seen;
      logic [PKT_W-1:0]      pkt;
      logic                  pkt_valid;
   } arpc_carry_type;

   // entry write and flush broadcast to every cell
   typedef struct packed {
      logic                  en;
      logic                  flush;
      logic [SLOT_IDX_W-1:0] idx;
      logic [IP_W-1:0]       key;
      arpc_slot_state_type   state;
      logic [MAC_W-1:0]      mac;
      logic [TIME_W-1:0]     last_seen;
      logic [PKT_W-1:0]      pkt;
      logic                  pkt_valid;
   } arpc_wr_type;

   // outcome of a command, held for the expiry check
   typedef struct packed {
      arpc_status_type     status;
      logic                found;
      logic                show;
      arpc_slot_state_type state;
      logic [MAC_W-1:0]    mac;
      logic [TIME_W-1:0]   last_seen;
      logic [PKT_W-1:0]    pkt;
      logic                pkt_valid;
      logic [TIME_W-1:0]   now;
   } arpc_rep_type;

endpackage

[hw/rtl/arpc_cell.sv]
// One slot of the ARP cache table and its stage of the search chain.
`timescale 1ns / 1ps

module arpc_cell
   import arpc_pkg::*;
#(
   parameter int HANDLE_BITS = HANDLE_BITS_DEF,
   parameter int INDEX       = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [IP_W-1:0]     search_ip,
   input  arpc_wr_type         wr,
   input  arpc_carry_type      carry_in,
   output arpc_carry_type      carry_out
);

   logic                   used_ff,  used_in;
   logic [IP_W-1:0]        key_ff;
   arpc_slot_state_type    state_ff;
   logic [MAC_W-1:0]       mac_ff;
   logic [TIME_W-1:0]      last_ff;
   logic [HANDLE_BITS-1:0] pkt_ff;
   logic                   pv_ff;
   arpc_carry_type         carry_ff, carry_in_next;
   logic                   wr_hit;

   assign wr_hit = wr.en && (wr.idx == SLOT_IDX_W'(INDEX));

   always_comb begin
      used_in = used_ff;
      if (wr.flush) begin
         used_in = 1'b0;
      end else if (wr_hit) begin
         used_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_hit) begin
         key_ff   <= wr.key;
         state_ff <= wr.state;
         mac_ff   <= wr.mac;
         last_ff  <= wr.last_seen;
         pkt_ff   <= HANDLE_BITS'(wr.pkt);
         pv_ff    <= wr.pkt_valid;
      end
   end

   // first matching slot wins, first free slot is remembered
   always_comb begin
      carry_in_next = carry_in;
      if (carry_in.valid) begin
         if (!carry_in.hit && used_ff && (key_ff == search_ip)) begin
            carry_in_next.hit       = 1'b1;
            carry_in_next.hit_idx   = SLOT_IDX_W'(INDEX);
            carry_in_next.state     = state_ff;
            carry_in_next.mac       = mac_ff;
            carry_in_next.last_seen = last_ff;
            carry_in_next.pkt       = PKT_W'(pkt_ff);
            carry_in_next.pkt_valid = pv_ff;
         end
         if (!carry_in.free && !used_ff) begin
            carry_in_next.free     = 1'b1;
            carry_in_next.free_idx = SLOT_IDX_W'(INDEX);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff.valid <= 1'b0;
      end else begin
         carry_ff <= carry_in_next;
      end
   end

   assign carry_out = carry_ff;

endmodule

[hw/rtl/arp_cache_table_unit.sv]
// Top level of the ARP cache table: command sequencer, timeouts and cell chain.
`timescale 1ns / 1ps

// ARP cache table keyed by IPv4 address.
// Request channel (req_valid, req_stall, req_data): one beat carries a command,
// the address, a MAC, a packet handle and the current time. Response channel
// (rsp_valid, rsp_stall, rsp_data): exactly one beat per request, in order.
// Timeouts sit behind a plain write port (csr_we, csr_index, csr_wdata); write
// them only while the table is idle.
// Each slot lives in one cell of a chain. A request launches a search token
// into the first cell; it moves one cell per cycle, picking up the first slot
// with a matching key and the first free slot. When it leaves the last cell the
// sequencer updates the chosen slot by a broadcast write in the same cycle,
// then checks expiry (one subtract and compare) in its report step.
// The delay from request beat to response beat is set mostly by the walk of the
// token along the chain. One command is in flight at a time, so the table takes
// no new request until the sequencer is back in its idle step.
// A finished response waits in the output register while the next request is
// taken; a stalled response holds, and the sequencer waits in its report step
// until the register frees.
// Reset clears every slot's used flag and restores the default timeouts; slot
// contents are left as they are and are never read before an add writes them.
module arp_cache_table_unit
   import arpc_pkg::*;
#(
   parameter int ENTRIES     = ENTRIES_DEF,
   parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  arpc_req_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output arpc_rsp_type          rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   arpc_fsm_type      state_ff, state_in;
   arpc_req_type      req_ff, req_in;
   logic              start_ff, start_in;
   arpc_rep_type      rep_ff, rep_in;
   arpc_rsp_type      rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0] alive_to_ff, dead_to_ff, wait_to_ff;

   arpc_carry_type    chain [0:ENTRIES];
   arpc_carry_type    found_c;
   arpc_wr_type       wr;

   logic [TIME_W-1:0] delta;
   logic [TIME_W-1:0] timeout;
   logic              out_free;

   // ---------------------------------------------------------------------
   // Timeout registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         alive_to_ff <= ALIVE_TIMEOUT_RST;
         dead_to_ff  <= DEAD_TIMEOUT_RST;
         wait_to_ff  <= WAIT_TIMEOUT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ALIVE_TIMEOUT: alive_to_ff <= TIME_W'(csr_wdata);
            CSR_DEAD_TIMEOUT:  dead_to_ff  <= TIME_W'(csr_wdata);
            CSR_WAIT_TIMEOUT:  wait_to_ff  <= TIME_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Cell chain: token enters at the head, result leaves at the tail
   // ---------------------------------------------------------------------
   always_comb begin
      chain[0]       = '0;
      chain[0].valid = start_ff;
   end

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      arpc_cell #(
         .HANDLE_BITS (HANDLE_BITS),
         .INDEX       (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .search_ip (req_ff.ip_addr),
         .wr        (wr),
         .carry_in  (chain[g]),
         .carry_out (chain[g+1])
      );
   end

   assign found_c = chain[ENTRIES];

   // ---------------------------------------------------------------------
   // Expiry check on the entry as it stands after the command
   // ---------------------------------------------------------------------
   assign delta = rep_ff.now - rep_ff.last_seen;

   always_comb begin
      case (rep_ff.state)
         ST_ALIVE: timeout = alive_to_ff;
         ST_DEAD:  timeout = dead_to_ff;
         ST_WAIT:  timeout = wait_to_ff;
         default:  timeout = '0;
      endcase
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // ---------------------------------------------------------------------
   // Sequencer: next state, slot update and response build
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      start_in     = 1'b0;
      rep_in       = rep_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall    = 1'b1;
      wr           = '0;

      case (state_ff)
         FSM_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               req_in   = req_data;
               start_in = 1'b1;
               state_in = FSM_SEARCH;
            end
         end

         FSM_SEARCH: begin
            if (found_c.valid) begin
               rep_in        = '0;
               rep_in.status = STATUS_OK;
               rep_in.state  = ST_ALIVE;
               rep_in.now    = req_ff.now;
               wr.key        = req_ff.ip_addr;
               case (req_ff.cmd)
                  CMD_FLUSH: begin
                     wr.flush = 1'b1;
                  end
                  CMD_NOP: ;
                  CMD_ADD: begin
                     // fresh alive entry: MAC, time and packet cleared
                     wr.state     = ST_ALIVE;
                     wr.mac       = '0;
                     wr.last_seen = '0;
                     wr.pkt       = '0;
                     wr.pkt_valid = 1'b0;
                     if (found_c.hit) begin
                        rep_in.found     = 1'b1;
                        rep_in.show      = 1'b1;
                        rep_in.pkt       = found_c.pkt;
                        rep_in.pkt_valid = found_c.pkt_valid;
                        wr.en            = 1'b1;
                        wr.idx           = found_c.hit_idx;
                     end else if (found_c.free) begin
                        rep_in.show = 1'b1;
                        wr.en       = 1'b1;
                        wr.idx      = found_c.free_idx;
                     end else begin
                        rep_in.status = STATUS_TABLE_FULL;
                     end
                  end
                  default: begin
                     if (!found_c.hit) begin
                        rep_in.status = STATUS_NOT_FOUND;
                     end else begin
                        rep_in.found     = 1'b1;
                        rep_in.show      = 1'b1;
                        rep_in.pkt       = found_c.pkt;
                        rep_in.pkt_valid = found_c.pkt_valid;
                        // start from the stored entry, change what the command asks
                        wr.idx       = found_c.hit_idx;
                        wr.state     = found_c.state;
                        wr.mac       = found_c.mac;
                        wr.last_seen = found_c.last_seen;
                        wr.pkt       = found_c.pkt;
                        wr.pkt_valid = found_c.pkt_valid;
                        case (req_ff.cmd)
                           CMD_MARK_WAIT: begin
                              if (found_c.state inside {ST_ALIVE, ST_DEAD}) begin
                                 wr.en        = 1'b1;
                                 wr.state     = ST_WAIT;
                                 wr.pkt       = req_ff.packet_handle;
                                 wr.pkt_valid = 1'b1;
                                 wr.last_seen = req_ff.now;
                              end else begin
                                 rep_in.status = STATUS_WRONG_STATE;
                              end
                           end
                           CMD_UPDATE_WAIT: begin
                              if (found_c.state == ST_WAIT) begin
                                 wr.en        = 1'b1;
                                 wr.pkt       = req_ff.packet_handle;
                                 wr.pkt_valid = 1'b1;
                              end else begin
                                 rep_in.status = STATUS_WRONG_STATE;
                              end
                           end
                           CMD_MARK_ALIVE: begin
                              if (found_c.state == ST_WAIT) begin
                                 wr.en        = 1'b1;
                                 wr.mac       = req_ff.mac_addr;
                                 wr.state     = ST_ALIVE;
                                 wr.last_seen = req_ff.now;
                                 wr.pkt_valid = 1'b0;
                              end else begin
                                 rep_in.status = STATUS_WRONG_STATE;
                              end
                           end
                           CMD_MARK_DEAD: begin
                              wr.en        = 1'b1;
                              wr.state     = ST_DEAD;
                              wr.last_seen = req_ff.now;
                           end
                           default: ;
                        endcase
                     end
                  end
               endcase
               // report the entry as it stands once the write lands
               if (rep_in.show) begin
                  rep_in.state     = wr.state;
                  rep_in.mac       = wr.mac;
                  rep_in.last_seen = wr.last_seen;
               end
               state_in = FSM_REPORT;
            end
         end

         FSM_REPORT: begin
            if (out_free) begin
               rsp_in.status       = rep_ff.status;
               rsp_in.found        = rep_ff.found;
               rsp_in.entry_state  = rep_ff.show ? rep_ff.state : ST_ALIVE;
               rsp_in.mac_out      = rep_ff.show ? rep_ff.mac : '0;
               rsp_in.packet_out   = rep_ff.pkt;
               rsp_in.packet_valid = rep_ff.pkt_valid;
               rsp_in.expired      = rep_ff.show && (delta >= timeout);
               rsp_valid_in        = 1'b1;
               state_in            = FSM_IDLE;
            end
         end

         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rep_ff <= rep_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[bench/arp_cache_table_unit_test.sv]
// Self-checking bench for the ARP cache table: directed and random commands against a shadow table.
`timescale 1ns / 1ps

module arp_cache_table_unit_test
   import arpc_pkg::*;
;

   localparam int SLOTS        = ENTRIES_DEF;
   localparam int POOL_SIZE    = 20;
   localparam int TAIL_CYCLES  = 40;
   localparam int RUN_LIMIT_NS = 2_000_000;
   localparam logic [PKT_W-1:0]     HANDLE_MASK  = {PKT_W{1'b1}} >> (PKT_W - HANDLE_BITS_DEF);
   // index 3 maps to no register; a write there must leave every timeout alone
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   // DUT-facing signals; the inputs are all known from time zero
   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   arpc_req_type          req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   arpc_rsp_type          rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow copy of the table and its timeouts (timeouts indexed by slot state)
   logic                tbl_used      [SLOTS] = '{default: 1'b0};
   logic [IP_W-1:0]     tbl_key       [SLOTS];
   arpc_slot_state_type tbl_state     [SLOTS];
   logic [MAC_W-1:0]    tbl_mac       [SLOTS];
   logic [TIME_W-1:0]   tbl_seen      [SLOTS];
   logic [PKT_W-1:0]    tbl_pkt       [SLOTS];
   logic                tbl_pkt_valid [SLOTS];
   logic [TIME_W-1:0]   tmo_ticks     [4] =
      '{ALIVE_TIMEOUT_RST, DEAD_TIMEOUT_RST, WAIT_TIMEOUT_RST, '0};

   // commands waiting to be driven and responses waiting to arrive
   arpc_req_type      queued_req  [$];
   arpc_rsp_type      awaited_rsp [$];
   logic [IP_W-1:0]   addr_pool   [POOL_SIZE];
   logic [TIME_W-1:0] tick_now = '0;

   int   queued_total  = 0;
   int   bad_count     = 0;
   int   checked_count = 0;
   int   expired_count = 0;
   int   status_seen   [4] = '{default: 0};
   int   req_gap_pct   = 25;
   int   rsp_stall_pct = 25;
   int   req_gap_left  = 0;
   int   rsp_stall_left = 0;
   bit   calm_run      = 1'b0;
   arpc_rsp_type want_rsp;

   arp_cache_table_unit #(
      .ENTRIES     (SLOTS),
      .HANDLE_BITS (HANDLE_BITS_DEF)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Resolve one command against the shadow table: return the response it
   // must produce and apply its effect, exactly as the block should.
   function automatic arpc_rsp_type resolve_arp_command(arpc_req_type r);
      arpc_rsp_type res;
      int           hit;
      int           slot_no;
      res     = '0;
      hit     = -1;
      slot_no = -1;
      if (r.cmd == CMD_FLUSH) begin
         foreach (tbl_used[i]) tbl_used[i] = 1'b0;
         return res;
      end
      if (r.cmd == CMD_NOP) return res;
      // scan downwards so the lowest matching and lowest free slots win
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (tbl_used[i] && tbl_key[i] == r.ip_addr) hit = i;
         if (!tbl_used[i]) slot_no = i;
      end
      if (hit >= 0) begin
         slot_no          = hit;
         res.found        = 1'b1;
         res.packet_out   = tbl_pkt[hit];
         res.packet_valid = tbl_pkt_valid[hit];
      end else if (r.cmd != CMD_ADD) begin
         res.status = STATUS_NOT_FOUND;
         return res;
      end else if (slot_no < 0) begin
         res.status = STATUS_TABLE_FULL;
         return res;
      end
      case (r.cmd)
         CMD_ADD: begin
            tbl_used[slot_no]      = 1'b1;
            tbl_key[slot_no]       = r.ip_addr;
            tbl_state[slot_no]     = ST_ALIVE;
            tbl_mac[slot_no]       = '0;
            tbl_seen[slot_no]      = '0;
            tbl_pkt[slot_no]       = '0;
            tbl_pkt_valid[slot_no] = 1'b0;
         end
         CMD_MARK_WAIT: begin
            if (!(tbl_state[slot_no] inside {ST_ALIVE, ST_DEAD})) begin
               res.status = STATUS_WRONG_STATE;
            end else begin
               tbl_state[slot_no]     = ST_WAIT;
               tbl_pkt[slot_no]       = r.packet_handle & HANDLE_MASK;
               tbl_pkt_valid[slot_no] = 1'b1;
               tbl_seen[slot_no]      = r.now;
            end
         end
         CMD_UPDATE_WAIT: begin
            if (tbl_state[slot_no] != ST_WAIT) begin
               res.status = STATUS_WRONG_STATE;
            end else begin
               tbl_pkt[slot_no]       = r.packet_handle & HANDLE_MASK;
               tbl_pkt_valid[slot_no] = 1'b1;
            end
         end
         CMD_MARK_ALIVE: begin
            if (tbl_state[slot_no] != ST_WAIT) begin
               res.status = STATUS_WRONG_STATE;
            end else begin
               tbl_mac[slot_no]       = r.mac_addr;
               tbl_state[slot_no]     = ST_ALIVE;
               tbl_seen[slot_no]      = r.now;
               tbl_pkt_valid[slot_no] = 1'b0;
            end
         end
         CMD_MARK_DEAD: begin
            tbl_state[slot_no] = ST_DEAD;
            tbl_seen[slot_no]  = r.now;
         end
         default: begin
         end
      endcase
      res.entry_state = tbl_state[slot_no];
      res.mac_out     = tbl_mac[slot_no];
      // age wraps modulo 2^32
      res.expired     = (r.now - tbl_seen[slot_no]) >= tmo_ticks[tbl_state[slot_no]];
      return res;
   endfunction

   function automatic string rsp_text(arpc_rsp_type r);
      return $sformatf("status %0d found %0d state %0d mac %h pkt %h valid %0d expired %0d",
                       r.status, r.found, r.entry_state, r.mac_out, r.packet_out,
                       r.packet_valid, r.expired);
   endfunction

   task automatic flag_bad_rsp(string what, arpc_rsp_type got);
      bad_count++;
      if (bad_count <= 10) begin
         $display("%0t: %s", $time, what);
         $display("   got  %s", rsp_text(got));
      end
   endtask

   // Advance the time stamp: mostly small steps, now and then a jump anywhere.
   function automatic logic [TIME_W-1:0] next_tick();
      if ($urandom_range(0, 19) == 0) tick_now = $urandom;
      else tick_now += $urandom_range(0, 120);
      return tick_now;
   endfunction

   function automatic logic [MAC_W-1:0] rand_mac();
      return {16'($urandom), 32'($urandom)};
   endfunction

   task automatic queue_req(arpc_cmd_type cmd, logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac,
                            logic [PKT_W-1:0] pkt, logic [TIME_W-1:0] stamp);
      arpc_req_type r;
      r.cmd           = cmd;
      r.ip_addr       = ip;
      r.mac_addr      = mac;
      r.packet_handle = pkt;
      r.now           = stamp;
      queued_req.push_back(r);
      queued_total++;
   endtask

   // Mostly whole entry lifetimes (add, wait on reply, resolve) on a small key
   // pool so slots fill up; the rest is flushes and stray commands.
   task automatic queue_random_phase(int count);
      int              goal;
      int              pick;
      logic [IP_W-1:0] ip;
      goal = queued_total + count;
      while (queued_total < goal) begin
         pick = $urandom_range(0, 99);
         ip   = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
         if (pick < 70) begin
            if ($urandom_range(0, 1) != 0)
               queue_req(CMD_ADD, ip, rand_mac(), 16'($urandom), next_tick());
            queue_req(CMD_MARK_WAIT, ip, rand_mac(), 16'($urandom), next_tick());
            repeat ($urandom_range(0, 2))
               queue_req(CMD_UPDATE_WAIT, ip, rand_mac(), 16'($urandom), next_tick());
            if ($urandom_range(0, 99) < 65)
               queue_req(CMD_MARK_ALIVE, ip, rand_mac(), 16'($urandom), next_tick());
            else
               queue_req(CMD_MARK_DEAD, ip, rand_mac(), 16'($urandom), next_tick());
            if ($urandom_range(0, 99) < 40)
               queue_req(CMD_LOOKUP, ip, rand_mac(), 16'($urandom), next_tick());
         end else if (pick < 72) begin
            queue_req(CMD_FLUSH, ip, rand_mac(), 16'($urandom), next_tick());
         end else begin
            if ($urandom_range(0, 99) < 30) ip = $urandom;
            queue_req(arpc_cmd_type'($urandom_range(0, 7)), ip, rand_mac(), 16'($urandom),
                      next_tick());
         end
      end
   endtask

   // Write one timeout register; only ever called with the table idle.
   task automatic program_timeout(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx != CSR_UNMAPPED) tmo_ticks[idx] = value;
   endtask

   // Hold until every queued command has been taken and answered. Sample on
   // the falling edge so the driver's and monitor's updates have all landed.
   task automatic settle();
      @(negedge clock);
      while (queued_req.size() != 0 || req_valid || awaited_rsp.size() != 0)
         @(negedge clock);
   endtask

   // Request driver: predict each accepted beat, then offer the next command
   // or an idle burst. Valid only drops after an accepted beat.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            awaited_rsp.push_back(resolve_arp_command(req_data));
         end
         if (!req_valid || !req_stall) begin
            if (req_gap_left > 0) begin
               req_gap_left--;
               req_valid <= 1'b0;
            end else if (!calm_run && queued_req.size() != 0 &&
                         $urandom_range(0, 99) < req_gap_pct) begin
               // start an idle burst, this one included
               req_gap_left = $urandom_range(0, 3);
               req_valid <= 1'b0;
            end else if (queued_req.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= queued_req.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: check each accepted beat against the oldest prediction,
   // and throw stall bursts at the response channel.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
               flag_bad_rsp("response beat with nothing awaited", rsp_data);
            end else begin
               want_rsp = awaited_rsp.pop_front();
               checked_count++;
               status_seen[want_rsp.status]++;
               if (want_rsp.expired) expired_count++;
               if (rsp_data.status !== want_rsp.status ||
                   rsp_data.found !== want_rsp.found ||
                   rsp_data.entry_state !== want_rsp.entry_state ||
                   rsp_data.mac_out !== want_rsp.mac_out ||
                   rsp_data.packet_out !== want_rsp.packet_out ||
                   rsp_data.packet_valid !== want_rsp.packet_valid ||
                   rsp_data.expired !== want_rsp.expired)
                  flag_bad_rsp($sformatf("response mismatch, want %s", rsp_text(want_rsp)),
                               rsp_data);
            end
         end
         if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_stall <= 1'b1;
         end else if (!calm_run && $urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_stall_left = $urandom_range(0, 3);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #RUN_LIMIT_NS;
      $display("timeout with %0d responses still awaited", awaited_rsp.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      // extreme keys first in the pool, random ones after
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = $urandom;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part, default timeouts. Fill every slot, then one add too many.
      for (int i = 0; i < SLOTS; i++)
         queue_req(CMD_ADD, addr_pool[i], '1, '1, (i == 1) ? '1 : TIME_W'(i));
      queue_req(CMD_ADD, addr_pool[SLOTS], '0, '0, 32'd20);
      // overwrite an existing key while the table is full
      queue_req(CMD_ADD, addr_pool[0], '0, '0, 32'd30);
      // precondition failures on an alive entry, then on a waiting one
      queue_req(CMD_MARK_ALIVE, addr_pool[0], '1, '0, 32'd40);
      queue_req(CMD_UPDATE_WAIT, addr_pool[0], '0, 16'h0001, 32'd50);
      queue_req(CMD_MARK_WAIT, addr_pool[0], '0, '1, 32'd100);
      queue_req(CMD_MARK_WAIT, addr_pool[0], '0, 16'h0002, 32'd110);
      // reply wait ages exactly to its timeout, then one tick short of it
      queue_req(CMD_UPDATE_WAIT, addr_pool[0], '0, '0, 32'd1100);
      queue_req(CMD_LOOKUP, addr_pool[0], '0, '0, 32'd1099);
      // reply arrives: packet released, then the alive timeout boundary
      queue_req(CMD_MARK_ALIVE, addr_pool[0], '1, '0, 32'd2000);
      queue_req(CMD_LOOKUP, addr_pool[0], '0, '0, 32'd121999);
      queue_req(CMD_LOOKUP, addr_pool[0], '0, '0, 32'd122000);
      // dead entries may wait again; an add displaces the held packet
      queue_req(CMD_MARK_DEAD, addr_pool[1], '0, '0, 32'd5);
      queue_req(CMD_MARK_WAIT, addr_pool[1], '0, 16'hA5A5, 32'd6);
      queue_req(CMD_ADD, addr_pool[1], '0, '0, 32'd7);
      queue_req(CMD_MARK_DEAD, addr_pool[SLOTS], '0, '0, 32'd8);
      queue_req(CMD_NOP, addr_pool[0], '1, '1, '1);
      queue_req(CMD_FLUSH, addr_pool[0], '1, '1, '1);
      queue_req(CMD_LOOKUP, addr_pool[0], '0, '0, 32'd9);
      settle();

      // alive entries expire at once, dead ones practically never
      req_gap_pct   = 30;
      rsp_stall_pct = 30;
      program_timeout(CSR_ALIVE_TIMEOUT, '0);
      program_timeout(CSR_DEAD_TIMEOUT, '1);
      program_timeout(CSR_WAIT_TIMEOUT, 32'd50);
      queue_random_phase(125);
      settle();

      // the other way round; long request gaps so beats land when the table is ready
      req_gap_pct   = 85;
      rsp_stall_pct = 10;
      program_timeout(CSR_ALIVE_TIMEOUT, '1);
      program_timeout(CSR_DEAD_TIMEOUT, '0);
      program_timeout(CSR_WAIT_TIMEOUT, '1);
      queue_random_phase(125);
      settle();

      // random small timeouts, no request gaps, heavy response back-pressure
      req_gap_pct   = 0;
      rsp_stall_pct = 60;
      program_timeout(CSR_ALIVE_TIMEOUT, 32'($urandom_range(0, 300)));
      program_timeout(CSR_DEAD_TIMEOUT, 32'($urandom_range(0, 300)));
      program_timeout(CSR_WAIT_TIMEOUT, 32'($urandom_range(0, 300)));
      program_timeout(CSR_UNMAPPED, $urandom);
      queue_random_phase(125);
      settle();

      // closing stretch at full rate on both sides
      calm_run = 1'b1;
      program_timeout(CSR_ALIVE_TIMEOUT, 32'd200);
      program_timeout(CSR_DEAD_TIMEOUT, 32'd150);
      program_timeout(CSR_WAIT_TIMEOUT, 32'd100);
      queue_random_phase(125);
      settle();

      // let any stray beat show up before judging
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("%0d commands answered: %0d ok, %0d not found, %0d wrong state, %0d full",
               checked_count, status_seen[STATUS_OK], status_seen[STATUS_NOT_FOUND],
               status_seen[STATUS_WRONG_STATE], status_seen[STATUS_TABLE_FULL]);
      $display("%0d expired entries over timeouts at zero, full scale and random; %0d bad",
               expired_count, bad_count);
      if (bad_count == 0 && awaited_rsp.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
